// ----- design/assert_macros.svh -----
// assertion helpers shared by the rtl files
// each macro expands to a named concurrent assertion, or to nothing when ASSERT_OFF is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- design/tilt_pkg.sv -----
// ----------------------------------------------------------------------------
// tilt_pkg
// types, constants, microcode program and arctangent table of the tilt block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tilt_pkg;

    // configuration of the algorithm
    localparam int CORDIC_ITERATIONS = 24;
    localparam int SAMPLE_BITS       = 16;

    // field widths
    localparam int IN_W      = 16;
    localparam int ANGLE_W   = 9;
    localparam int ID_W      = 8;

    // fixed-point formats
    localparam int FRAC_BITS = 24;
    localparam int PRESHIFT  = 32 - SAMPLE_BITS;
    localparam int MAG_W     = SAMPLE_BITS;
    localparam int XY_W      = 35;
    localparam int ACC_W     = 33;
    localparam int TAB_W     = 31;
    localparam int TAB_IDX_W = 5;
    localparam int DEG_W     = 7;
    localparam int ITER_W    = $clog2(CORDIC_ITERATIONS);
    localparam int QUAD_W    = 2;

    // largest whole degree within one quadrant
    localparam logic [DEG_W-1:0] DEG_MAX = DEG_W'(89);
    localparam logic signed [ACC_W-1:0] QUARTER_FIXED = ACC_W'(90 * (2 ** FRAC_BITS));

    // sequencer
    localparam int PC_W   = 3;
    localparam int OP_W   = 3;
    localparam int COND_W = 3;

    localparam logic [OP_W-1:0] OP_NOP    = OP_W'(0);
    localparam logic [OP_W-1:0] OP_LOAD   = OP_W'(1);
    localparam logic [OP_W-1:0] OP_ROTATE = OP_W'(2);
    localparam logic [OP_W-1:0] OP_ANGLE  = OP_W'(3);
    localparam logic [OP_W-1:0] OP_EMIT   = OP_W'(4);

    localparam logic [COND_W-1:0] COND_NEVER     = COND_W'(0);
    localparam logic [COND_W-1:0] COND_NO_INPUT  = COND_W'(1);
    localparam logic [COND_W-1:0] COND_ZERO      = COND_W'(2);
    localparam logic [COND_W-1:0] COND_MORE_ITER = COND_W'(3);
    localparam logic [COND_W-1:0] COND_OUT_BUSY  = COND_W'(4);
    localparam logic [COND_W-1:0] COND_ALWAYS    = COND_W'(5);

    localparam logic [PC_W-1:0] PC_IDLE   = PC_W'(0);
    localparam logic [PC_W-1:0] PC_CHECK  = PC_W'(1);
    localparam logic [PC_W-1:0] PC_ROTATE = PC_W'(2);
    localparam logic [PC_W-1:0] PC_ANGLE  = PC_W'(3);
    localparam logic [PC_W-1:0] PC_EMIT   = PC_W'(4);
    localparam logic [PC_W-1:0] PC_WRAP   = PC_W'(5);

    // payload types
    typedef struct packed {
        logic signed [IN_W-1:0] y_sample;
        logic signed [IN_W-1:0] z_sample;
    } t_in_item;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle_deg;
        logic [ID_W-1:0]    sender_id;
    } t_out_item;

    // one control word of the program
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } t_uword;

    // enables from sequencer to datapath
    typedef struct packed {
        logic load_step;
        logic load;
        logic rotate;
        logic angle;
        logic emit;
    } t_ctrl;

    // flags from datapath to sequencer
    typedef struct packed {
        logic zero;
        logic more_iter;
    } t_status;

    // microcode program: jump to target when cond holds, else step on
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            PC_IDLE:   w = '{op: OP_LOAD,   cond: COND_NO_INPUT,  target: PC_IDLE};
            PC_CHECK:  w = '{op: OP_NOP,    cond: COND_ZERO,      target: PC_EMIT};
            PC_ROTATE: w = '{op: OP_ROTATE, cond: COND_MORE_ITER, target: PC_ROTATE};
            PC_ANGLE:  w = '{op: OP_ANGLE,  cond: COND_NEVER,     target: PC_IDLE};
            PC_EMIT:   w = '{op: OP_EMIT,   cond: COND_OUT_BUSY,  target: PC_EMIT};
            PC_WRAP:   w = '{op: OP_NOP,    cond: COND_ALWAYS,    target: PC_IDLE};
            default:   w = '{op: OP_NOP,    cond: COND_ALWAYS,    target: PC_IDLE};
        endcase
        return w;
    endfunction

    // atan(2^-k) in degrees, 24 fractional bits, rounded to nearest
    function automatic logic [TAB_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] k);
        logic [TAB_W-1:0] v;
        case (k)
            5'd0:    v = TAB_W'(754974720);
            5'd1:    v = TAB_W'(445687602);
            5'd2:    v = TAB_W'(235489088);
            5'd3:    v = TAB_W'(119537938);
            5'd4:    v = TAB_W'(60000934);
            5'd5:    v = TAB_W'(30029717);
            5'd6:    v = TAB_W'(15018523);
            5'd7:    v = TAB_W'(7509720);
            5'd8:    v = TAB_W'(3754917);
            5'd9:    v = TAB_W'(1877466);
            5'd10:   v = TAB_W'(938734);
            5'd11:   v = TAB_W'(469367);
            5'd12:   v = TAB_W'(234684);
            5'd13:   v = TAB_W'(117342);
            5'd14:   v = TAB_W'(58671);
            5'd15:   v = TAB_W'(29335);
            5'd16:   v = TAB_W'(14668);
            5'd17:   v = TAB_W'(7334);
            5'd18:   v = TAB_W'(3667);
            5'd19:   v = TAB_W'(1833);
            5'd20:   v = TAB_W'(917);
            5'd21:   v = TAB_W'(458);
            5'd22:   v = TAB_W'(229);
            5'd23:   v = TAB_W'(115);
            5'd24:   v = TAB_W'(57);
            5'd25:   v = TAB_W'(29);
            5'd26:   v = TAB_W'(14);
            5'd27:   v = TAB_W'(7);
            5'd28:   v = TAB_W'(4);
            5'd29:   v = TAB_W'(2);
            5'd30:   v = TAB_W'(1);
            default: v = TAB_W'(0);
        endcase
        return v;
    endfunction

    // degrees at the start of each quadrant
    function automatic logic [ANGLE_W-1:0] quad_base(input logic [QUAD_W-1:0] q);
        logic [ANGLE_W-1:0] b;
        case (q)
            2'd0:    b = ANGLE_W'(0);
            2'd1:    b = ANGLE_W'(90);
            2'd2:    b = ANGLE_W'(180);
            default: b = ANGLE_W'(270);
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- design/tilt_angle_from_two_axes.sv -----
// An item is a signed Y and Z sample; each yields one result with the tilt angle in whole
// degrees (0 to 359) and the source identifier. One item is worked on at a time: the next
// item is accepted only after the result of the last one has been loaded, which waits while
// the output stalls and a result is still held. The work is done by the single shift-add
// cordic unit, which does one rotation per microcode step; when an axis is zero the rotations
// are skipped and the previous angle is repeated. A finished result sits in the output
// register while the next item is accepted and worked on. source_id is written over the
// config channel, which is always ready.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tilt_angle_from_two_axes (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // input items
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire tilt_pkg::t_in_item       i_in_item,
    // result items
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output tilt_pkg::t_out_item           o_out_item,
    // configuration write
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [tilt_pkg::ID_W-1:0] i_cfg_data
);

    tilt_pkg::t_ctrl                 ctrl;
    tilt_pkg::t_status               status;
    logic [tilt_pkg::ANGLE_W-1:0]    last_angle;
    logic                            out_busy;
    logic                            in_acc;

    logic [tilt_pkg::ID_W-1:0]       r_source_id;
    logic                            r_out_valid;
    tilt_pkg::t_out_item             r_out_item;

    // source identifier register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_id <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_source_id <= i_cfg_data;
        end
    end

    // input side
    assign o_in_stall = !ctrl.load_step;
    assign in_acc     = i_in_valid && !o_in_stall;

    // output register is full and held by the consumer
    assign out_busy = r_out_valid && i_out_stall;

    tilt_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_busy (out_busy),
        .i_status   (status),
        .o_ctrl     (ctrl)
    );

    tilt_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_item       (i_in_item),
        .o_status     (status),
        .o_last_angle (last_angle)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.emit) begin
            r_out_item.angle_deg <= last_angle;
            r_out_item.sender_id <= r_source_id;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // checks
    `ASSERT_IMPLIES(a_angle_range, i_clk, i_rst_n, r_out_valid, r_out_item.angle_deg <= tilt_pkg::ANGLE_W'(359), "angle out of range")
    `ASSERT_NEXT(a_no_emit_after_accept, i_clk, i_rst_n, in_acc, !ctrl.emit, "result loaded right after an item was accepted")
    `ASSERT_IMPLIES(a_no_overwrite, i_clk, i_rst_n, ctrl.emit, !out_busy, "held result overwritten")
    `ASSERT_IMPLIES(a_no_accept_in_emit, i_clk, i_rst_n, ctrl.emit, o_in_stall, "item accepted while a result is loaded")

endmodule

`default_nettype wire

// ----- design/tilt_sequencer.sv -----
// ----------------------------------------------------------------------------
// tilt_sequencer
// step counter over the microcode program, with conditional jumps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tilt_sequencer (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_out_busy,
    input  wire tilt_pkg::t_status i_status,
    output tilt_pkg::t_ctrl       o_ctrl
);

    logic [tilt_pkg::PC_W-1:0] r_pc;
    logic [tilt_pkg::PC_W-1:0] n_pc;
    tilt_pkg::t_uword          uw;
    logic                      cond_true;

    // fetch the current control word
    assign uw = tilt_pkg::ucode(r_pc);

    // jump condition
    always_comb begin
        case (uw.cond)
            tilt_pkg::COND_NEVER:     cond_true = 1'b0;
            tilt_pkg::COND_NO_INPUT:  cond_true = !i_in_valid;
            tilt_pkg::COND_ZERO:      cond_true = i_status.zero;
            tilt_pkg::COND_MORE_ITER: cond_true = i_status.more_iter;
            tilt_pkg::COND_OUT_BUSY:  cond_true = i_out_busy;
            tilt_pkg::COND_ALWAYS:    cond_true = 1'b1;
            default:                  cond_true = 1'b1;
        endcase
    end

    // next step
    assign n_pc = cond_true ? uw.target : r_pc + tilt_pkg::PC_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= tilt_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // decode the operation into datapath enables
    always_comb begin
        o_ctrl           = '0;
        o_ctrl.load_step = (uw.op == tilt_pkg::OP_LOAD);
        o_ctrl.load      = (uw.op == tilt_pkg::OP_LOAD) && i_in_valid;
        o_ctrl.rotate    = (uw.op == tilt_pkg::OP_ROTATE);
        o_ctrl.angle     = (uw.op == tilt_pkg::OP_ANGLE);
        o_ctrl.emit      = (uw.op == tilt_pkg::OP_EMIT) && !i_out_busy;
    end

endmodule

`default_nettype wire

// ----- design/tilt_datapath.sv -----
// ----------------------------------------------------------------------------
// tilt_datapath
// quadrant set-up, one cordic vectoring rotation per step, angle fix-up
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tilt_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire tilt_pkg::t_ctrl                 i_ctrl,
    input  wire tilt_pkg::t_in_item              i_item,
    output tilt_pkg::t_status                    o_status,
    output logic [tilt_pkg::ANGLE_W-1:0]         o_last_angle
);

    localparam int SB = tilt_pkg::SAMPLE_BITS;

    logic signed [tilt_pkg::XY_W-1:0]   r_x;
    logic signed [tilt_pkg::XY_W-1:0]   r_y;
    logic signed [tilt_pkg::ACC_W-1:0]  r_acc;
    logic [tilt_pkg::ITER_W-1:0]        r_iter;
    logic [tilt_pkg::QUAD_W-1:0]        r_quad;
    logic                               r_zero;
    logic [tilt_pkg::ANGLE_W-1:0]       r_last_angle;

    logic signed [SB-1:0]               y_low;
    logic signed [SB-1:0]               z_low;
    logic [tilt_pkg::MAG_W-1:0]         y_mag;
    logic [tilt_pkg::MAG_W-1:0]         z_mag;
    logic [tilt_pkg::MAG_W-1:0]         num_mag;
    logic [tilt_pkg::MAG_W-1:0]         den_mag;
    logic [tilt_pkg::QUAD_W-1:0]        quad;
    logic [tilt_pkg::TAB_IDX_W-1:0]     k;
    logic signed [tilt_pkg::XY_W-1:0]   dx;
    logic signed [tilt_pkg::XY_W-1:0]   dy;
    logic signed [tilt_pkg::ACC_W-1:0]  tab;
    logic [tilt_pkg::DEG_W-1:0]         deg;

    // sample set-up: low bits, magnitudes and quadrant
    assign y_low = i_item.y_sample[SB-1:0];
    assign z_low = i_item.z_sample[SB-1:0];
    assign y_mag = y_low[SB-1] ? tilt_pkg::MAG_W'(-y_low) : tilt_pkg::MAG_W'(y_low);
    assign z_mag = z_low[SB-1] ? tilt_pkg::MAG_W'(-z_low) : tilt_pkg::MAG_W'(z_low);
    assign quad  = {!y_low[SB-1], (!y_low[SB-1]) ^ (!z_low[SB-1])};
    // odd quadrants take the ratio the other way round
    assign num_mag = quad[0] ? z_mag : y_mag;
    assign den_mag = quad[0] ? y_mag : z_mag;

    // one rotation
    assign k   = tilt_pkg::TAB_IDX_W'(r_iter);
    assign dx  = r_y >>> k;
    assign dy  = r_x >>> k;
    assign tab = signed'(tilt_pkg::ACC_W'(tilt_pkg::atan_entry(k)));

    // saturate to one quadrant and keep whole degrees
    always_comb begin
        if (r_acc[tilt_pkg::ACC_W-1]) begin
            deg = '0;
        end else if (r_acc >= tilt_pkg::QUARTER_FIXED) begin
            deg = tilt_pkg::DEG_MAX;
        end else begin
            deg = r_acc[tilt_pkg::FRAC_BITS +: tilt_pkg::DEG_W];
        end
    end

    // cordic working registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_x    <= signed'(tilt_pkg::XY_W'({den_mag, {tilt_pkg::PRESHIFT{1'b0}}}));
            r_y    <= signed'(tilt_pkg::XY_W'({num_mag, {tilt_pkg::PRESHIFT{1'b0}}}));
            r_acc  <= '0;
            r_quad <= quad;
            r_zero <= (y_low == '0) || (z_low == '0);
        end else if (i_ctrl.rotate) begin
            if (!r_y[tilt_pkg::XY_W-1]) begin
                r_x   <= r_x + dx;
                r_y   <= r_y - dy;
                r_acc <= r_acc + tab;
            end else begin
                r_x   <= r_x - dx;
                r_y   <= r_y + dy;
                r_acc <= r_acc - tab;
            end
        end
    end

    // iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter <= '0;
        end else if (i_ctrl.load) begin
            r_iter <= '0;
        end else if (i_ctrl.rotate) begin
            r_iter <= r_iter + tilt_pkg::ITER_W'(1);
        end
    end

    // most recent angle, held when an axis is zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_angle <= '0;
        end else if (i_ctrl.angle) begin
            r_last_angle <= tilt_pkg::quad_base(r_quad) + tilt_pkg::ANGLE_W'(deg);
        end
    end

    assign o_status.zero      = r_zero;
    assign o_status.more_iter = (r_iter != tilt_pkg::ITER_W'(tilt_pkg::CORDIC_ITERATIONS - 1));
    assign o_last_angle       = r_last_angle;

endmodule

`default_nettype wire
